// ===== rtl/gdcpm_pkg.sv =====
// Package for the GPS duty-cycle power manager.
// Holds the mode type, register indexes, register widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package gdcpm_pkg;

	// Width of every configuration register and of its write data
	localparam int REG_WIDTH = 24;
	// Width of the configuration register index
	localparam int CFG_IDX_WIDTH = 3;

	// Register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] IDX_REPORT_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] IDX_FIX_TIMEOUT     = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] IDX_STILL_SLEEP     = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] IDX_POWER_CYCLE     = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] IDX_NOFIX_RETRY     = 3'd4;

	// Register reset values, in ticks
	localparam logic [REG_WIDTH-1:0] RST_REPORT_INTERVAL = 24'd30000;
	localparam logic [REG_WIDTH-1:0] RST_FIX_TIMEOUT     = 24'd60000;
	localparam logic [REG_WIDTH-1:0] RST_STILL_SLEEP     = 24'd30000;
	localparam logic [REG_WIDTH-1:0] RST_POWER_CYCLE     = 24'd300000;
	localparam logic [REG_WIDTH-1:0] RST_NOFIX_RETRY     = 24'd120000;

	// Receiver power mode
	typedef enum logic [1:0] {
		MODE_LOCATE  = 2'd0,
		MODE_STANDBY = 2'd1,
		MODE_RETRY   = 2'd2
	} mode_t;

	// Threshold registers as seen by the step logic
	typedef struct packed {
		logic [REG_WIDTH-1:0] report_interval;
		logic [REG_WIDTH-1:0] fix_timeout;
		logic [REG_WIDTH-1:0] still_sleep;
		logic [REG_WIDTH-1:0] power_cycle;
		logic [REG_WIDTH-1:0] nofix_retry;
	} cfg_regs_t;

endpackage

// ===== rtl/gdcpm_cfg.sv =====
// Configuration register file of the GPS duty-cycle power manager.
// Five threshold registers written through a valid/ready channel.
// Depends on gdcpm_pkg.
`timescale 1ns / 1ps

module gdcpm_cfg
	import gdcpm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0]     cfg_data,
	output cfg_regs_t                regs
);

	cfg_regs_t regs_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Register writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.report_interval <= RST_REPORT_INTERVAL;
			regs_q.fix_timeout     <= RST_FIX_TIMEOUT;
			regs_q.still_sleep     <= RST_STILL_SLEEP;
			regs_q.power_cycle     <= RST_POWER_CYCLE;
			regs_q.nofix_retry     <= RST_NOFIX_RETRY;
		end else if (cfg_valid) begin
			case (cfg_index)
				IDX_REPORT_INTERVAL: regs_q.report_interval <= cfg_data;
				IDX_FIX_TIMEOUT:     regs_q.fix_timeout     <= cfg_data;
				IDX_STILL_SLEEP:     regs_q.still_sleep     <= cfg_data;
				IDX_POWER_CYCLE:     regs_q.power_cycle     <= cfg_data;
				IDX_NOFIX_RETRY:     regs_q.nofix_retry     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== rtl/gdcpm_core.sv =====
// Step logic of the GPS duty-cycle power manager: mode, two saturating
// tick counters and the result register with its stream handshake.
// Depends on gdcpm_pkg.
`timescale 1ns / 1ps

module gdcpm_core
	import gdcpm_pkg::*;
#(
	parameter int TIMER_WIDTH = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_regs_t regs,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      has_fix,
	input  logic      receiver_moved,
	input  logic      motion_seen,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      power_enable,
	output logic      report_now,
	output mode_t     mode_out
);

	// Compare width: one bit above the wider operand so both get zero padding
	localparam int CW = ((TIMER_WIDTH > REG_WIDTH) ? TIMER_WIDTH : REG_WIDTH) + 1;

	mode_t                  mode_q;
	logic [TIMER_WIDTH-1:0] time_in_mode_q;
	logic [TIMER_WIDTH-1:0] time_since_report_q;

	logic                   out_valid_q;
	logic                   power_q;
	logic                   report_q;
	mode_t                  mode_out_q;

	logic                   in_fire;
	logic [TIMER_WIDTH-1:0] tim_inc;
	logic [TIMER_WIDTH-1:0] tsr_inc;
	logic [CW-1:0]          tim_ext;
	logic [CW-1:0]          tsr_ext;
	logic                   ge_report;
	logic                   ge_fix_to;
	logic                   ge_still;
	logic                   ge_cycle;
	logic                   ge_retry;
	mode_t                  mode_next;
	logic                   enter_mode;
	logic                   report;

	// Input taken whenever the result register is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Saturating tick advance
	assign tim_inc = (&time_in_mode_q) ? time_in_mode_q
	                                   : time_in_mode_q + TIMER_WIDTH'(1);
	assign tsr_inc = (&time_since_report_q) ? time_since_report_q
	                                        : time_since_report_q + TIMER_WIDTH'(1);

	// Threshold compares; zero padding makes out-of-range thresholds unreachable
	assign tim_ext   = {{(CW-TIMER_WIDTH){1'b0}}, tim_inc};
	assign tsr_ext   = {{(CW-TIMER_WIDTH){1'b0}}, tsr_inc};
	assign ge_report = tsr_ext >= {{(CW-REG_WIDTH){1'b0}}, regs.report_interval};
	assign ge_fix_to = tim_ext >= {{(CW-REG_WIDTH){1'b0}}, regs.fix_timeout};
	assign ge_still  = tim_ext >= {{(CW-REG_WIDTH){1'b0}}, regs.still_sleep};
	assign ge_cycle  = tim_ext >= {{(CW-REG_WIDTH){1'b0}}, regs.power_cycle};
	assign ge_retry  = tim_ext >= {{(CW-REG_WIDTH){1'b0}}, regs.nofix_retry};

	// Next mode and report decision
	always_comb begin
		mode_next  = mode_q;
		enter_mode = 1'b0;
		report     = 1'b0;
		case (mode_q)
			MODE_STANDBY: begin
				if ((motion_seen && ge_still) || ge_cycle) begin
					mode_next  = MODE_LOCATE;
					enter_mode = 1'b1;
				end
			end
			MODE_RETRY: begin
				if (ge_retry) begin
					mode_next  = MODE_LOCATE;
					enter_mode = 1'b1;
				end
			end
			default: begin
				// locating, and any unknown code treated as locating
				if (has_fix) begin
					report     = receiver_moved || ge_report;
					mode_next  = MODE_STANDBY;
					enter_mode = 1'b1;
				end else if (ge_fix_to) begin
					mode_next  = MODE_RETRY;
					enter_mode = 1'b1;
				end else begin
					mode_next  = MODE_LOCATE;
				end
			end
		endcase
	end

	// State update per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q              <= MODE_LOCATE;
			time_in_mode_q      <= '0;
			time_since_report_q <= '0;
		end else if (in_fire) begin
			mode_q              <= mode_next;
			time_in_mode_q      <= enter_mode ? '0 : tim_inc;
			time_since_report_q <= report ? '0 : tsr_inc;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			power_q    <= (mode_next == MODE_LOCATE);
			report_q   <= report;
			mode_out_q <= mode_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign power_enable = power_q;
	assign report_now   = report_q;
	assign mode_out     = mode_out_q;

	// A report only comes with the move into standby
	a_report_standby: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && report_q |-> mode_out_q == MODE_STANDBY)
		else $error("report without standby entry");

	// Power follows the result mode
	a_power_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> power_q == (mode_out_q == MODE_LOCATE))
		else $error("power_enable does not match mode");

	// Result mode equals the state left behind
	a_mode_track: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> mode_out_q == mode_q)
		else $error("result mode differs from state");

	// Mode change clears the time-in-mode counter
	a_tim_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && enter_mode |=> time_in_mode_q == '0)
		else $error("time in mode not cleared on entry");

	// A report clears the time-since-report counter
	a_tsr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && report |=> time_since_report_q == '0)
		else $error("time since report not cleared");

endmodule

// ===== rtl/gps_duty_cycle_power_manager.sv =====
// Top level of the GPS duty-cycle power manager.
// Instantiates gdcpm_cfg and gdcpm_core; depends on gdcpm_pkg.
`timescale 1ns / 1ps

// One input request per millisecond tick carries the fix, moved and motion
// flags; each request yields exactly one result with power enable, report
// request and the new mode. For each request the counters advance, five
// threshold compares and the mode decision settle between the state
// registers and the result register, so a new request is accepted every
// cycle as long as results are taken; while a result waits in the result
// register the input is held off. Counters are TIMER_WIDTH bits and
// saturate. Configuration writes are always accepted in the cycle they
// arrive and take effect on the next request.
module gps_duty_cycle_power_manager
	import gdcpm_pkg::*;
#(
	parameter int TIMER_WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Tick input
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [7:0]               s_axis_tdata,  // [0] has_fix, [1] receiver_moved,
	                                                // [2] motion_seen, [7:3] zero
	// Result output
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [7:0]               m_axis_tdata,  // [0] power_enable, [1] report_now,
	                                                // [3:2] mode_out, [7:4] zero
	// Configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0]     cfg_data
);

	cfg_regs_t regs;
	logic      power_enable;
	logic      report_now;
	mode_t     mode_out;

	// Threshold registers
	gdcpm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Mode logic and result register
	gdcpm_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.regs           (regs),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.has_fix        (s_axis_tdata[0]),
		.receiver_moved (s_axis_tdata[1]),
		.motion_seen    (s_axis_tdata[2]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.power_enable   (power_enable),
		.report_now     (report_now),
		.mode_out       (mode_out)
	);

	// Result packing
	assign m_axis_tdata = {4'b0000, mode_out, report_now, power_enable};

endmodule
